>>> src/mac_grid_pressure_gradient_apply_defines.svh
// ----------------------------------------------------------------------------
// mac grid pressure gradient apply: assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef MAC_GRID_PRESSURE_GRADIENT_APPLY_DEFINES_SVH
`define MAC_GRID_PRESSURE_GRADIENT_APPLY_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MGPG_ASSERT_IMPL(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication
`define MGPG_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`else

`define MGPG_ASSERT_IMPL(label, cond, expr, msg)

`define MGPG_ASSERT_NEXT(label, cond, expr, msg)

`endif

`endif

>>> src/mgpg_pkg.sv
// ----------------------------------------------------------------------------
// mgpg_pkg
// shared constants, register codes and types of the gradient apply block
// ----------------------------------------------------------------------------
package mgpg_pkg;

    localparam int DATA_W              = 32;
    localparam int SCALE_W             = 32;
    localparam int CELLS_W             = 7;
    localparam int CFG_ADDR_W          = 4;
    localparam int CFG_DATA_W          = 32;
    localparam int AXES                = 3;
    localparam int ROUND_SHIFT         = 24;
    localparam int QUEUE_DEPTH         = 4;
    localparam int MAX_CELLS_DEFAULT   = 64;
    localparam int VALUE_BITS_DEFAULT  = 32;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd16777216;
    localparam logic [CELLS_W-1:0] CELLS_RESET = 7'd64;

    // register word index on the config port
    typedef enum logic [1:0] {
        REG_GRADIENT_SCALE = 2'd0,
        REG_CELLS_X        = 2'd1,
        REG_CELLS_Y        = 2'd2,
        REG_CELLS_Z        = 2'd3
    } cfg_reg_t;

    // per-cell classification made by the front end
    typedef struct packed {
        logic corr_u;
        logic corr_v;
        logic corr_w;
        logic last_cell;
    } mgpg_flags_t;

    localparam int FLAGS_W = $bits(mgpg_flags_t);

    typedef struct packed {
        logic push;
        logic last_cell;
        logic at_origin;
    } mgpg_front_status_t;

    // value width used inside the datapath, capped at the field width
    function automatic int vbits(int value_bits);
        return (value_bits > DATA_W) ? DATA_W : value_bits;
    endfunction

    // width of one queued cell descriptor
    function automatic int desc_width(int max_x, int max_y, int value_bits);
        return FLAGS_W + $clog2(max_x) + $clog2(max_x * max_y) + 4 * vbits(value_bits);
    endfunction

endpackage

>>> src/mgpg_if.sv
// ----------------------------------------------------------------------------
// mgpg channel interfaces
// valid/ready channels for input cells and corrected face velocities
// ----------------------------------------------------------------------------
interface mgpg_in_if import mgpg_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] cell_pressure;
    logic signed [DATA_W-1:0] face_u;
    logic signed [DATA_W-1:0] face_v;
    logic signed [DATA_W-1:0] face_w;

    modport source (output valid, output cell_pressure, output face_u, output face_v,
                    output face_w, input ready);
    modport sink (input valid, input cell_pressure, input face_u, input face_v,
                  input face_w, output ready);
endinterface

interface mgpg_out_if import mgpg_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] new_u;
    logic signed [DATA_W-1:0] new_v;
    logic signed [DATA_W-1:0] new_w;
    logic                     grid_done;

    modport source (output valid, output new_u, output new_v, output new_w,
                    output grid_done, input ready);
    modport sink (input valid, input new_u, input new_v, input new_w,
                  input grid_done, output ready);
endinterface

>>> src/mac_grid_pressure_gradient_apply.sv
// path: an input transfer passes the queue, ram read, difference, multiply, rounding,
//   and correct and saturate stages in turn; a stalled output holds its result back
// throughput: one cell per cycle unless the output stalls; one multiplier per axis
// reset: rst_n clears the raster position, the queue and the pipeline valids, and loads
//   the registers with scale 1.0 and 64 cells per axis; the pressure stores need no clearing
// ----------------------------------------------------------------------------
// mac_grid_pressure_gradient_apply
// streams mac grid cells in raster order and subtracts the scaled pressure
// gradient from the three low-face velocities
// ----------------------------------------------------------------------------
`include "mac_grid_pressure_gradient_apply_defines.svh"

module mac_grid_pressure_gradient_apply import mgpg_pkg::*; #(
    parameter int MAX_CELLS_X = MAX_CELLS_DEFAULT,
    parameter int MAX_CELLS_Y = MAX_CELLS_DEFAULT,
    parameter int MAX_CELLS_Z = MAX_CELLS_DEFAULT,
    parameter int VALUE_BITS  = VALUE_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // config port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    // cell stream in, corrected velocities out
    mgpg_in_if.sink               cell_in,
    mgpg_out_if.source            cell_out
);

    localparam int DESC_W = desc_width(MAX_CELLS_X, MAX_CELLS_Y, VALUE_BITS);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    logic [SCALE_W-1:0] gradient_scale_reg;
    logic [CELLS_W-1:0] cells_x_reg;
    logic [CELLS_W-1:0] cells_y_reg;
    logic [CELLS_W-1:0] cells_z_reg;
    logic               cfg_write;
    cfg_reg_t           cfg_sel;

    logic               queue_push;
    logic [DESC_W-1:0]  queue_push_data;
    logic               queue_pop;
    logic               queue_empty;
    logic               queue_full;
    logic [CNT_W-1:0]   queue_count;
    logic [DESC_W-1:0]  queue_head;

    mgpg_front_status_t front_status;
    logic               last_cell_push;

    // ------------------------------------------------------------------------
    // config registers: word addressed, written on the access phase
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_sel   = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gradient_scale_reg <= SCALE_RESET;
            cells_x_reg        <= CELLS_RESET;
            cells_y_reg        <= CELLS_RESET;
            cells_z_reg        <= CELLS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_GRADIENT_SCALE: gradient_scale_reg <= pwdata[SCALE_W-1:0];
                REG_CELLS_X:        cells_x_reg        <= pwdata[CELLS_W-1:0];
                REG_CELLS_Y:        cells_y_reg        <= pwdata[CELLS_W-1:0];
                REG_CELLS_Z:        cells_z_reg        <= pwdata[CELLS_W-1:0];
            endcase
        end
    end

    // read back of the selected register
    always_comb
    begin
        unique case (cfg_sel)
            REG_GRADIENT_SCALE: prdata = CFG_DATA_W'(gradient_scale_reg);
            REG_CELLS_X:        prdata = CFG_DATA_W'(cells_x_reg);
            REG_CELLS_Y:        prdata = CFG_DATA_W'(cells_y_reg);
            REG_CELLS_Z:        prdata = CFG_DATA_W'(cells_z_reg);
        endcase
    end

    // ------------------------------------------------------------------------
    // front end: takes a cell whenever the queue has room, stamps it with
    // its store addresses and which axes get a correction
    // ------------------------------------------------------------------------
    mgpg_front #(
        .MAX_CELLS_X (MAX_CELLS_X),
        .MAX_CELLS_Y (MAX_CELLS_Y),
        .MAX_CELLS_Z (MAX_CELLS_Z),
        .VALUE_BITS  (VALUE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cells_x    (cells_x_reg),
        .cells_y    (cells_y_reg),
        .cells_z    (cells_z_reg),
        .cell_in    (cell_in),
        .queue_full (queue_full),
        .push       (queue_push),
        .push_data  (queue_push_data),
        .status     (front_status)
    );

    // ------------------------------------------------------------------------
    // decoupling queue: input keeps flowing for up to four cells while the
    // result side is stalled
    // ------------------------------------------------------------------------
    mgpg_fifo #(
        .WIDTH (DESC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (queue_push),
        .push_data (queue_push_data),
        .pop       (queue_pop),
        .empty     (queue_empty),
        .full      (queue_full),
        .count     (queue_count),
        .head      (queue_head)
    );

    // ------------------------------------------------------------------------
    // back end: lower-neighbour pressures from the left register, the row
    // store and the plane store, then difference, multiply, round, saturate;
    // the last stage is the output register
    // ------------------------------------------------------------------------
    mgpg_back #(
        .MAX_CELLS_X (MAX_CELLS_X),
        .MAX_CELLS_Y (MAX_CELLS_Y),
        .VALUE_BITS  (VALUE_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .gradient_scale (gradient_scale_reg),
        .head_valid     (!queue_empty),
        .head_data      (queue_head),
        .pop            (queue_pop),
        .cell_out       (cell_out)
    );

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------

    // transfer of the last cell of a grid
    assign last_cell_push = front_status.push && front_status.last_cell;

    // the front end never pushes into a full queue
    `MGPG_ASSERT_IMPL(a_queue_no_overflow, front_status.push, !queue_full, "queue overflow")

    // an accepted cell is held in the queue on the next cycle
    `MGPG_ASSERT_NEXT(a_queue_holds_push, front_status.push, queue_count != '0, "push lost")

    // the last cell of a grid sends the raster position back to the origin
    `MGPG_ASSERT_NEXT(a_wrap_to_origin, last_cell_push, front_status.at_origin, "missed wrap")

endmodule

>>> src/mgpg_ram.sv
// ----------------------------------------------------------------------------
// mgpg_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mgpg_ram import mgpg_pkg::*; #(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = MAX_CELLS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/mgpg_fifo.sv
// ----------------------------------------------------------------------------
// mgpg_fifo
// short register queue between the front end and the back end
// ----------------------------------------------------------------------------
module mgpg_fifo import mgpg_pkg::*; #(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic                       empty,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] count,
    output logic [WIDTH-1:0]           head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign count = count_reg;
    assign head  = slot_reg[rd_ptr_reg];

endmodule

>>> src/mgpg_front.sv
// ----------------------------------------------------------------------------
// mgpg_front
// accepts cells, tracks the raster position and classifies each cell
// ----------------------------------------------------------------------------
module mgpg_front import mgpg_pkg::*; #(
    parameter int MAX_CELLS_X = MAX_CELLS_DEFAULT,
    parameter int MAX_CELLS_Y = MAX_CELLS_DEFAULT,
    parameter int MAX_CELLS_Z = MAX_CELLS_DEFAULT,
    parameter int VALUE_BITS  = VALUE_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [CELLS_W-1:0]       cells_x,
    input  logic [CELLS_W-1:0]       cells_y,
    input  logic [CELLS_W-1:0]       cells_z,
    mgpg_in_if.sink                  cell_in,
    input  logic                     queue_full,
    output logic                     push,
    output logic [desc_width(MAX_CELLS_X, MAX_CELLS_Y, VALUE_BITS)-1:0] push_data,
    output mgpg_front_status_t       status
);

    localparam int VB   = vbits(VALUE_BITS);
    localparam int XW   = $clog2(MAX_CELLS_X);
    localparam int YW   = $clog2(MAX_CELLS_Y);
    localparam int ZW   = $clog2(MAX_CELLS_Z);
    localparam int PW   = $clog2(MAX_CELLS_X * MAX_CELLS_Y);
    localparam int XEW  = XW + 1;
    localparam int YEW  = YW + 1;
    localparam int ZEW  = ZW + 1;
    localparam int CMPX = (XEW > CELLS_W) ? XEW : CELLS_W;
    localparam int CMPY = (YEW > CELLS_W) ? YEW : CELLS_W;
    localparam int CMPZ = (ZEW > CELLS_W) ? ZEW : CELLS_W;

    logic [XW-1:0]  col_reg, col_next;
    logic [YW-1:0]  row_reg, row_next;
    logic [ZW-1:0]  layer_reg, layer_next;
    logic [XEW-1:0] nx;
    logic [YEW-1:0] ny;
    logic [ZEW-1:0] nz;
    logic           last_x, last_y, last_z;
    mgpg_flags_t    flags;
    logic [PW-1:0]  plane_addr;

    // effective extents: zero acts as one, above the maximum clamps
    always_comb
    begin
        if (cells_x == '0)
            nx = XEW'(1);
        else if (CMPX'(cells_x) > CMPX'(MAX_CELLS_X))
            nx = XEW'(MAX_CELLS_X);
        else
            nx = XEW'(cells_x);

        if (cells_y == '0)
            ny = YEW'(1);
        else if (CMPY'(cells_y) > CMPY'(MAX_CELLS_Y))
            ny = YEW'(MAX_CELLS_Y);
        else
            ny = YEW'(cells_y);

        if (cells_z == '0)
            nz = ZEW'(1);
        else if (CMPZ'(cells_z) > CMPZ'(MAX_CELLS_Z))
            nz = ZEW'(MAX_CELLS_Z);
        else
            nz = ZEW'(cells_z);
    end

    assign last_x = (XEW'(col_reg) + XEW'(1)) >= nx;
    assign last_y = (YEW'(row_reg) + YEW'(1)) >= ny;
    assign last_z = (ZEW'(layer_reg) + ZEW'(1)) >= nz;

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        layer_next = layer_reg;
        if (!last_x)
        begin
            col_next = col_reg + XW'(1);
        end
        else
        begin
            col_next = '0;
            if (!last_y)
            begin
                row_next = row_reg + YW'(1);
            end
            else
            begin
                row_next   = '0;
                layer_next = last_z ? '0 : layer_reg + ZW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            layer_reg <= '0;
        end
        else if (push)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            layer_reg <= layer_next;
        end
    end

    always_comb
    begin
        flags.corr_u    = (col_reg != '0);
        flags.corr_v    = (row_reg != '0);
        flags.corr_w    = (layer_reg != '0);
        flags.last_cell = last_x && last_y && last_z;
    end

    assign plane_addr = PW'(row_reg) * PW'(MAX_CELLS_X) + PW'(col_reg);

    assign cell_in.ready = !queue_full;
    assign push          = cell_in.valid && !queue_full;

    // descriptor: flags | row addr | plane addr | p | u | v | w
    assign push_data = {flags, col_reg, plane_addr,
                        cell_in.cell_pressure[VB-1:0], cell_in.face_u[VB-1:0],
                        cell_in.face_v[VB-1:0], cell_in.face_w[VB-1:0]};

    always_comb
    begin
        status.push      = push;
        status.last_cell = flags.last_cell;
        status.at_origin = (col_reg == '0) && (row_reg == '0) && (layer_reg == '0);
    end

endmodule

>>> src/mgpg_back.sv
// ----------------------------------------------------------------------------
// mgpg_back
// neighbour pressure stores and the three-axis gradient correction pipeline
// ----------------------------------------------------------------------------
module mgpg_back import mgpg_pkg::*; #(
    parameter int MAX_CELLS_X = MAX_CELLS_DEFAULT,
    parameter int MAX_CELLS_Y = MAX_CELLS_DEFAULT,
    parameter int VALUE_BITS  = VALUE_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [SCALE_W-1:0] gradient_scale,
    input  logic               head_valid,
    input  logic [desc_width(MAX_CELLS_X, MAX_CELLS_Y, VALUE_BITS)-1:0] head_data,
    output logic               pop,
    mgpg_out_if.source         cell_out
);

    localparam int VB     = vbits(VALUE_BITS);
    localparam int DW     = VB + 1;
    localparam int XW     = $clog2(MAX_CELLS_X);
    localparam int PW     = $clog2(MAX_CELLS_X * MAX_CELLS_Y);
    localparam int PROD_W = VB + SCALE_W;
    localparam int Q_W    = PROD_W - ROUND_SHIFT;
    localparam int RW     = VB + 10;
    localparam int W_OFF  = 0;
    localparam int V_OFF  = VB;
    localparam int U_OFF  = 2 * VB;
    localparam int P_OFF  = 3 * VB;
    localparam int PA_OFF = 4 * VB;
    localparam int RA_OFF = PA_OFF + PW;
    localparam int FL_OFF = RA_OFF + XW;

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (ROUND_SHIFT - 1);

    logic                 adv;
    mgpg_flags_t          head_flags;
    logic [XW-1:0]        head_row_addr;
    logic [PW-1:0]        head_plane_addr;
    logic signed [VB-1:0] head_p;
    logic signed [VB-1:0] head_vel [AXES];
    logic [VB-1:0]        row_q, plane_q;
    logic signed [VB-1:0] left_reg;

    logic                 s1_valid_reg;
    mgpg_flags_t          s1_flags_reg;
    logic signed [VB-1:0] s1_p_reg;
    logic signed [VB-1:0] s1_left_reg;
    logic signed [VB-1:0] s1_vel_reg [AXES];

    logic                 s2_valid_reg;
    mgpg_flags_t          s2_flags_reg;
    logic [VB-1:0]        s2_mag_reg [AXES];
    logic                 s2_neg_reg [AXES];
    logic signed [VB-1:0] s2_vel_reg [AXES];

    logic                 s3_valid_reg;
    mgpg_flags_t          s3_flags_reg;
    logic [PROD_W-1:0]    s3_prod_reg [AXES];
    logic                 s3_neg_reg [AXES];
    logic signed [VB-1:0] s3_vel_reg [AXES];

    logic                 s4_valid_reg;
    mgpg_flags_t          s4_flags_reg;
    logic [Q_W-1:0]       s4_q_reg [AXES];
    logic                 s4_neg_reg [AXES];
    logic signed [VB-1:0] s4_vel_reg [AXES];

    logic                     s5_valid_reg;
    logic                     s5_done_reg;
    logic signed [DATA_W-1:0] s5_u_reg, s5_v_reg, s5_w_reg;

    logic signed [VB-1:0] plow [AXES];
    logic [VB-1:0]        mag [AXES];
    logic                 neg [AXES];
    logic [PROD_W-1:0]    rounded [AXES];
    logic signed [VB-1:0] corrected [AXES];
    logic                 corr_en [AXES];

    // whole pipeline moves together; stalls only on a held result
    assign adv = !s5_valid_reg || cell_out.ready;
    assign pop = adv && head_valid;

    assign head_flags      = mgpg_flags_t'(head_data[FL_OFF +: FLAGS_W]);
    assign head_row_addr   = head_data[RA_OFF +: XW];
    assign head_plane_addr = head_data[PA_OFF +: PW];
    assign head_p          = signed'(head_data[P_OFF +: VB]);
    assign head_vel[0]     = signed'(head_data[U_OFF +: VB]);
    assign head_vel[1]     = signed'(head_data[V_OFF +: VB]);
    assign head_vel[2]     = signed'(head_data[W_OFF +: VB]);

    // read of the lower neighbour and write of this cell share one edge
    mgpg_ram #(
        .WIDTH (VB),
        .DEPTH (MAX_CELLS_X)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (pop),
        .wr_addr (head_row_addr),
        .wr_data (head_p),
        .rd_en   (pop),
        .rd_addr (head_row_addr),
        .rd_data (row_q)
    );

    mgpg_ram #(
        .WIDTH (VB),
        .DEPTH (MAX_CELLS_X * MAX_CELLS_Y)
    ) u_plane_ram (
        .clk     (clk),
        .wr_en   (pop),
        .wr_addr (head_plane_addr),
        .wr_data (head_p),
        .rd_en   (pop),
        .rd_addr (head_plane_addr),
        .rd_data (plane_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= pop;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // pressure difference and its magnitude
    always_comb
    begin
        logic signed [DW-1:0] diff;
        plow[0] = s1_left_reg;
        plow[1] = signed'(row_q);
        plow[2] = signed'(plane_q);
        for (int a = 0; a < AXES; a++)
        begin
            diff   = DW'(s1_p_reg) - DW'(plow[a]);
            neg[a] = diff[DW-1];
            mag[a] = neg[a] ? VB'(-diff) : VB'(diff);
        end
    end

    // rounding to nearest, ties away from zero on the magnitude
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            rounded[a] = s3_prod_reg[a] + ROUND_HALF;
        end
    end

    // apply correction and saturate to the value range
    always_comb
    begin
        logic signed [RW-1:0] vel_ext;
        logic signed [RW-1:0] q_ext;
        logic signed [RW-1:0] sum;
        logic signed [VB-1:0] sat;
        corr_en[0] = s4_flags_reg.corr_u;
        corr_en[1] = s4_flags_reg.corr_v;
        corr_en[2] = s4_flags_reg.corr_w;
        for (int a = 0; a < AXES; a++)
        begin
            vel_ext = RW'(s4_vel_reg[a]);
            q_ext   = signed'(RW'(s4_q_reg[a]));
            sum     = s4_neg_reg[a] ? vel_ext + q_ext : vel_ext - q_ext;
            if ((sum[RW-1:VB-1] == '0) || (sum[RW-1:VB-1] == '1))
                sat = sum[VB-1:0];
            else if (sum[RW-1])
                sat = {1'b1, {(VB-1){1'b0}}};
            else
                sat = {1'b0, {(VB-1){1'b1}}};
            corrected[a] = corr_en[a] ? sat : s4_vel_reg[a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            left_reg <= head_p;
        end
        if (adv)
        begin
            s1_flags_reg <= head_flags;
            s1_p_reg     <= head_p;
            s1_left_reg  <= left_reg;
            s2_flags_reg <= s1_flags_reg;
            s3_flags_reg <= s2_flags_reg;
            s4_flags_reg <= s3_flags_reg;
            s5_done_reg  <= s4_flags_reg.last_cell;
            s5_u_reg     <= DATA_W'(corrected[0]);
            s5_v_reg     <= DATA_W'(corrected[1]);
            s5_w_reg     <= DATA_W'(corrected[2]);
            for (int a = 0; a < AXES; a++)
            begin
                s1_vel_reg[a]  <= head_vel[a];
                s2_mag_reg[a]  <= mag[a];
                s2_neg_reg[a]  <= neg[a];
                s2_vel_reg[a]  <= s1_vel_reg[a];
                s3_prod_reg[a] <= PROD_W'(s2_mag_reg[a]) * PROD_W'(gradient_scale);
                s3_neg_reg[a]  <= s2_neg_reg[a];
                s3_vel_reg[a]  <= s2_vel_reg[a];
                s4_q_reg[a]    <= rounded[a][PROD_W-1:ROUND_SHIFT];
                s4_neg_reg[a]  <= s3_neg_reg[a];
                s4_vel_reg[a]  <= s3_vel_reg[a];
            end
        end
    end

    assign cell_out.valid     = s5_valid_reg;
    assign cell_out.new_u     = s5_u_reg;
    assign cell_out.new_v     = s5_v_reg;
    assign cell_out.new_w     = s5_w_reg;
    assign cell_out.grid_done = s5_done_reg;

endmodule

>>> test/tb_mac_grid_pressure_gradient_apply.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mac_grid_pressure_gradient_apply
// streams mac grid cells through the gradient apply block with random gaps
// on both channels, predicts every corrected face velocity in raster order
// and compares each result transfer field by field; scale and extents are
// reprogrammed between phases, mid-grid only by shrinking
// ----------------------------------------------------------------------------
module tb_mac_grid_pressure_gradient_apply;
    import mgpg_pkg::*;

    localparam int GRID_MAX     = MAX_CELLS_DEFAULT;
    localparam int TARGET_CELLS = 1600;
    localparam int DRAIN_CYCLES = 12;
    localparam int REPORT_LIMIT = 10;

    localparam logic signed [DATA_W-1:0] VEL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] VEL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] NEG_ONE = {DATA_W{1'b1}};

    // flavors of random cell content
    typedef enum int {
        MIX_ANY,
        MIX_PHYSICAL,
        MIX_EXTREME
    } mix_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pressure;
        logic signed [DATA_W-1:0] u;
        logic signed [DATA_W-1:0] v;
        logic signed [DATA_W-1:0] w;
    } cell_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] u;
        logic signed [DATA_W-1:0] v;
        logic signed [DATA_W-1:0] w;
        logic                     done;
    } faces_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    mgpg_in_if  cell_in();
    mgpg_out_if cell_out();

    mac_grid_pressure_gradient_apply dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cell_in  (cell_in),
        .cell_out (cell_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit, far above the slowest legal run
    initial
    begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // gradient predictor state: programmed registers, raster position and
    // the three pressure stores
    // ------------------------------------------------------------------------
    logic [SCALE_W-1:0]       cur_scale;
    logic [CELLS_W-1:0]       ext_x;
    logic [CELLS_W-1:0]       ext_y;
    logic [CELLS_W-1:0]       ext_z;
    int                       pos_x;
    int                       pos_y;
    int                       pos_z;
    logic signed [DATA_W-1:0] last_p;
    logic signed [DATA_W-1:0] row_p [GRID_MAX];
    logic signed [DATA_W-1:0] plane_p [GRID_MAX*GRID_MAX];

    cell_t  cell_backlog [$];    // cells waiting for the input driver
    faces_t expected_faces [$];  // predicted velocities, oldest first
    int     mismatches;
    int     cells_queued;

    // idle controls, changed only at the falling edge
    bit in_idle;
    bit out_idle;

    // handshakes and result fields captured at the falling edge, when
    // everything is settled, and used at the next rising edge
    bit     in_taken;
    bit     out_taken;
    faces_t out_seen;

    // extent in use: zero acts as one, oversize saturates
    function automatic int span(logic [CELLS_W-1:0] cells);
        if (cells == '0)
            return 1;
        return (cells > GRID_MAX) ? GRID_MAX : int'(cells);
    endfunction

    // v - scale * (p - p_low), magnitude rounded half away from zero, saturated
    function automatic logic signed [DATA_W-1:0] corrected(
        logic signed [DATA_W-1:0] vel,
        logic signed [DATA_W-1:0] p,
        logic signed [DATA_W-1:0] p_low
    );
        longint          diff;
        longint unsigned mag;
        longint unsigned scaled;
        longint          result;
        diff   = longint'(p) - longint'(p_low);
        mag    = (diff < 0) ? -diff : diff;
        scaled = (mag * 64'(cur_scale) + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
        result = longint'(vel) - ((diff < 0) ? -longint'(scaled) : longint'(scaled));
        if (result > longint'(VEL_MAX))
            return VEL_MAX;
        if (result < longint'(VEL_MIN))
            return VEL_MIN;
        return result[DATA_W-1:0];
    endfunction

    // one accepted cell: correct the faces above index zero, update the
    // stores, queue the expected result and step the raster position
    function automatic void predict_faces(cell_t c);
        faces_t res;
        int     slot;
        bit     end_x;
        bit     end_y;
        bit     end_z;
        slot  = pos_y * GRID_MAX + pos_x;
        end_x = (pos_x + 1 >= span(ext_x));
        end_y = (pos_y + 1 >= span(ext_y));
        end_z = (pos_z + 1 >= span(ext_z));

        res.u    = (pos_x != 0) ? corrected(c.u, c.pressure, last_p) : c.u;
        res.v    = (pos_y != 0) ? corrected(c.v, c.pressure, row_p[pos_x]) : c.v;
        res.w    = (pos_z != 0) ? corrected(c.w, c.pressure, plane_p[slot]) : c.w;
        res.done = end_x && end_y && end_z;
        expected_faces.push_back(res);

        last_p         = c.pressure;
        row_p[pos_x]   = c.pressure;
        plane_p[slot]  = c.pressure;

        // an index past a shrunk extent wraps as if it were the last
        if (!end_x)
            pos_x++;
        else
        begin
            pos_x = 0;
            if (!end_y)
                pos_y++;
            else
            begin
                pos_y = 0;
                pos_z = end_z ? 0 : pos_z + 1;
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic signed [DATA_W-1:0] edge_value();
        case ($urandom_range(0, 5))
            0:       return VEL_MIN;
            1:       return VEL_MAX;
            2:       return '0;
            3:       return NEG_ONE;
            4:       return 1;
            default: return $urandom;
        endcase
    endfunction

    function automatic cell_t random_cell(mix_t mix);
        cell_t c;
        case (mix)
            MIX_PHYSICAL:
            begin
                // pressures within +-16, velocities within +-64, both Q16.16
                c.pressure = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
                c.u        = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
                c.v        = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
                c.w        = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
            end
            MIX_EXTREME:
                c = {edge_value(), edge_value(), edge_value(), edge_value()};
            default:
                c = {$urandom, $urandom, $urandom, $urandom};
        endcase
        return c;
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return SCALE_RESET;
            3:       return 32'h0080_0000;
            4:       return $urandom;
            default: return $urandom_range(0, 32'h0400_0000);
        endcase
    endfunction

    // extent for a fresh grid: mostly small, sometimes zero or oversize
    function automatic logic [CELLS_W-1:0] fresh_extent();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return CELLS_W'(GRID_MAX);
            2:       return CELLS_W'($urandom_range(GRID_MAX + 1, 127));
            default: return CELLS_W'($urandom_range(1, 6));
        endcase
    endfunction

    // mid-grid change: never larger than the extent in use, so every store
    // entry that gets read has been written
    function automatic logic [CELLS_W-1:0] shrunk(logic [CELLS_W-1:0] cells);
        if ($urandom_range(0, 7) == 0)
            return '0;
        return CELLS_W'($urandom_range(1, span(cells)));
    endfunction

    // register write: setup cycle, then access until pready
    task automatic reg_write(cfg_reg_t sel, logic [CFG_DATA_W-1:0] value);
        bit ready_seen;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({sel, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            ready_seen = pready;
            @(posedge clk);
        end while (!ready_seen);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            REG_GRADIENT_SCALE: cur_scale = value[SCALE_W-1:0];
            REG_CELLS_X:        ext_x     = value[CELLS_W-1:0];
            REG_CELLS_Y:        ext_y     = value[CELLS_W-1:0];
            REG_CELLS_Z:        ext_z     = value[CELLS_W-1:0];
            default:            ;
        endcase
    endtask

    task automatic queue_cells(int count, mix_t mix, logic [1:0] idle_mode);
        @(negedge clk);
        in_idle  = idle_mode[0];
        out_idle = idle_mode[1];
        repeat (count)
            cell_backlog.push_back(random_cell(mix));
        cells_queued += count;
    endtask

    // every cell transferred and every result back, then a short pause
    task automatic wait_idle();
        do
        begin
            @(negedge clk);
        end while (cell_backlog.size() != 0 || cell_in.valid || expected_faces.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // falling edge capture
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        in_taken  = cell_in.valid && cell_in.ready;
        out_taken = cell_out.valid && cell_out.ready;
        out_seen  = {cell_out.new_u, cell_out.new_v, cell_out.new_w, cell_out.grid_done};
    end

    // ------------------------------------------------------------------------
    // input driver: predicts on each transfer, then offers the next cell
    // after a random gap if in_idle is set, else with no gap
    // ------------------------------------------------------------------------
    int    gap_left;
    cell_t next_cell;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cell_in.valid <= 1'b0;
            gap_left      <= 0;
        end
        else
        begin
            if (in_taken)
                predict_faces({cell_in.cell_pressure, cell_in.face_u, cell_in.face_v,
                               cell_in.face_w});
            if (in_taken || !cell_in.valid)
            begin
                if (gap_left != 0)
                begin
                    cell_in.valid <= 1'b0;
                    gap_left      <= gap_left - 1;
                end
                else if (cell_backlog.size() != 0)
                begin
                    next_cell = cell_backlog.pop_front();
                    cell_in.valid         <= 1'b1;
                    cell_in.cell_pressure <= next_cell.pressure;
                    cell_in.face_u        <= next_cell.u;
                    cell_in.face_v        <= next_cell.v;
                    cell_in.face_w        <= next_cell.w;
                    gap_left              <= in_idle ? $urandom_range(0, 10) : 0;
                end
                else
                begin
                    cell_in.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: compares each transfer with the oldest prediction and
    // draws a stall, when out_idle is set, before the next one
    // ------------------------------------------------------------------------
    int     stall_left;
    int     stall_now;
    faces_t want;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cell_out.ready <= 1'b0;
            stall_left     <= 0;
        end
        else
        begin
            stall_now = stall_left;
            if (out_taken)
            begin
                if (expected_faces.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected result u=%h v=%h w=%h done=%b", $time,
                                 out_seen.u, out_seen.v, out_seen.w, out_seen.done);
                end
                else
                begin
                    want = expected_faces.pop_front();
                    if (out_seen.u !== want.u || out_seen.v !== want.v ||
                        out_seen.w !== want.w || out_seen.done !== want.done)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: exp u=%h v=%h w=%h d=%b got u=%h v=%h w=%h d=%b",
                                     $time, want.u, want.v, want.w, want.done,
                                     out_seen.u, out_seen.v, out_seen.w, out_seen.done);
                    end
                end
                stall_now = out_idle ? $urandom_range(0, 10) : 0;
            end
            if (stall_now != 0)
            begin
                cell_out.ready <= 1'b0;
                stall_left     <= stall_now - 1;
            end
            else
            begin
                cell_out.ready <= 1'b1;
                stall_left     <= 0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        bit         at_origin;
        logic [1:0] idle_mode;

        // every input known from time zero
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        cell_in.valid         = 1'b0;
        cell_in.cell_pressure = '0;
        cell_in.face_u        = '0;
        cell_in.face_v        = '0;
        cell_in.face_w        = '0;
        cell_out.ready        = 1'b0;
        in_idle               = 1'b0;
        out_idle              = 1'b0;
        mismatches            = 0;
        cells_queued          = 0;

        // predictor starts from the reset register values at the origin
        cur_scale = SCALE_RESET;
        ext_x     = CELLS_RESET;
        ext_y     = CELLS_RESET;
        ext_z     = CELLS_RESET;
        pos_x     = 0;
        pos_y     = 0;
        pos_z     = 0;
        last_p    = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // 2x2x2 grid at full scale: every axis combination, differences of
        // full span in both directions, saturation high and low
        reg_write(REG_GRADIENT_SCALE, '1);
        reg_write(REG_CELLS_X, 2);
        reg_write(REG_CELLS_Y, 2);
        reg_write(REG_CELLS_Z, 2);
        @(negedge clk);
        cell_backlog.push_back('{VEL_MIN, VEL_MAX, VEL_MAX, VEL_MAX});
        cell_backlog.push_back('{VEL_MAX, VEL_MIN, VEL_MIN, VEL_MIN});
        cell_backlog.push_back('{VEL_MAX, 0, VEL_MIN, 0});
        cell_backlog.push_back('{VEL_MIN, VEL_MAX, VEL_MAX, VEL_MAX});
        cell_backlog.push_back('{0, 1, NEG_ONE, VEL_MIN});
        cell_backlog.push_back('{0, 12345, 0, VEL_MAX});
        cell_backlog.push_back('{NEG_ONE, 0, 0, 0});
        cell_backlog.push_back('{1, VEL_MIN, VEL_MIN, VEL_MIN});
        wait_idle();

        // half scale on one row: rounding ties of both signs, zero difference
        reg_write(REG_GRADIENT_SCALE, 32'h0080_0000);
        reg_write(REG_CELLS_X, 4);
        reg_write(REG_CELLS_Y, 1);
        reg_write(REG_CELLS_Z, 1);
        @(negedge clk);
        cell_backlog.push_back('{0, 100, 100, 100});
        cell_backlog.push_back('{1, 100, 100, 100});
        cell_backlog.push_back('{0, 100, 100, 100});
        cell_backlog.push_back('{0, 100, 100, 100});
        wait_idle();

        // zero extents act as one: every cell is the whole grid
        reg_write(REG_GRADIENT_SCALE, '0);
        reg_write(REG_CELLS_X, 0);
        reg_write(REG_CELLS_Y, 0);
        reg_write(REG_CELLS_Z, 0);
        @(negedge clk);
        cell_backlog.push_back('{VEL_MAX, VEL_MIN, NEG_ONE, 1});
        cell_backlog.push_back('{VEL_MIN, VEL_MAX, 0, NEG_ONE});
        wait_idle();

        // oversize extents saturate; then x shrinks behind the position,
        // which wraps onto the next row
        reg_write(REG_GRADIENT_SCALE, SCALE_RESET);
        reg_write(REG_CELLS_X, 127);
        reg_write(REG_CELLS_Y, 127);
        reg_write(REG_CELLS_Z, 127);
        queue_cells(4, MIX_PHYSICAL, 2'b00);
        wait_idle();
        reg_write(REG_CELLS_X, 2);
        queue_cells(3, MIX_PHYSICAL, 2'b00);
        wait_idle();
        cells_queued = 0;

        // random phases
        while (cells_queued < TARGET_CELLS)
        begin
            at_origin = (pos_x == 0 && pos_y == 0 && pos_z == 0);
            // collapse to a single cell so the next cell ends the grid
            if (!at_origin && $urandom_range(0, 2) == 0)
            begin
                reg_write(REG_CELLS_X, $urandom_range(0, 1));
                reg_write(REG_CELLS_Y, $urandom_range(0, 1));
                reg_write(REG_CELLS_Z, $urandom_range(0, 1));
                queue_cells(1, MIX_ANY, 2'b00);
                wait_idle();
                at_origin = 1'b1;
            end
            if ($urandom_range(0, 3) != 0)
                reg_write(REG_GRADIENT_SCALE, pick_scale());
            if (at_origin && $urandom_range(0, 4) < 4)
            begin
                reg_write(REG_CELLS_X, fresh_extent());
                reg_write(REG_CELLS_Y, fresh_extent());
                reg_write(REG_CELLS_Z, fresh_extent());
            end
            else if (!at_origin && $urandom_range(0, 3) == 0)
            begin
                reg_write(REG_CELLS_X, shrunk(ext_x));
                reg_write(REG_CELLS_Y, shrunk(ext_y));
                reg_write(REG_CELLS_Z, shrunk(ext_z));
            end
            idle_mode = 2'($urandom_range(0, 3));
            queue_cells($urandom_range(8, 120), mix_t'($urandom_range(0, 2)), idle_mode);
            wait_idle();
        end

        // late extra results show up as unexpected
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (expected_faces.size() != 0)
        begin
            $display("%0d expected results never arrived", expected_faces.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/mgpg_pkg.sv
src/mgpg_if.sv
src/mgpg_ram.sv
src/mgpg_fifo.sv
src/mgpg_front.sv
src/mgpg_back.sv
src/mac_grid_pressure_gradient_apply.sv
test/tb_mac_grid_pressure_gradient_apply.sv
